@@ src/clce_pkg.sv @@
// ----------------------------------------------------------------------------
// clce_pkg
// Shared constants, operation and status codes, and the slot pool interface
// types for the circular list cursor engine.
// ----------------------------------------------------------------------------
package clce_pkg;

    localparam int CAPACITY    = 64;
    localparam int SLOT_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int VALUE_W     = 32;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;
    localparam logic [FUNC_W-1:0] FN_UPDATE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic  start;
        logic  take;
        logic  give;
        slot_t slot;
    } pool_cmd_t;

    typedef struct packed {
        logic  done;
        slot_t slot;
    } pool_resp_t;

endpackage

@@ src/clce_ram.sv @@
// ----------------------------------------------------------------------------
// clce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/clce_slot_pool.sv @@
// ----------------------------------------------------------------------------
// clce_slot_pool
// Free-slot flags with a one-slot-per-cycle scan for the lowest free slot.
// ----------------------------------------------------------------------------
module clce_slot_pool (
    input  logic                  clk,
    input  logic                  rst_n,
    input  clce_pkg::pool_cmd_t   cmd,
    output clce_pkg::pool_resp_t  resp
);

    logic [clce_pkg::CAPACITY-1:0] free_reg;
    logic [clce_pkg::CAPACITY-1:0] free_next;
    logic                          scanning_reg;
    logic                          scanning_next;
    clce_pkg::slot_t               idx_reg;
    clce_pkg::slot_t               idx_next;

    assign resp.done = scanning_reg & free_reg[idx_reg];
    assign resp.slot = idx_reg;

    always_comb
    begin
        free_next     = free_reg;
        scanning_next = scanning_reg;
        idx_next      = idx_reg;
        if (cmd.take)
        begin
            free_next[cmd.slot] = 1'b0;
        end
        if (cmd.give)
        begin
            free_next[cmd.slot] = 1'b1;
        end
        if (cmd.start)
        begin
            scanning_next = 1'b1;
            idx_next      = '0;
        end
        else if (scanning_reg)
        begin
            if (free_reg[idx_reg])
            begin
                scanning_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + clce_pkg::slot_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg     <= '1;
            scanning_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            free_reg     <= free_next;
            scanning_reg <= scanning_next;
            idx_reg      <= idx_next;
        end
    end

endmodule

@@ src/circular_list_cursor_engine_core.sv @@
// ----------------------------------------------------------------------------
// circular_list_cursor_engine_core: circular linked list with head and cursor
// One item at a time; a full insert or a lookup on an empty list goes straight to the finish
// step, other items pass through the list walk and the free-slot scan, one entry or slot per
// cycle. The finish step holds until the previous result is taken; the next item can be taken
// in the cycle the result is raised.
// rst_n clears control state and frees every slot; list RAMs are not cleared.
// ----------------------------------------------------------------------------
module circular_list_cursor_engine_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [clce_pkg::FUNC_W-1:0]            func,
    input  logic signed [clce_pkg::VALUE_W-1:0]    value,
    input  logic signed [clce_pkg::VALUE_W-1:0]    new_value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [clce_pkg::STATUS_W-1:0]          status,
    output logic [clce_pkg::COUNT_OUT_W-1:0]       count
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN     = 8'b0000_0010,
        S_INS_LINK = 8'b0000_0100,
        S_INS_HOOK = 8'b0000_1000,
        S_WALK     = 8'b0001_0000,
        S_TAIL     = 8'b0010_0000,
        S_REM_WR   = 8'b0100_0000,
        S_FIN      = 8'b1000_0000
    } state_t;

    state_t                                 state_reg, state_next;
    logic [clce_pkg::FUNC_W-1:0]            func_reg, func_next;
    logic signed [clce_pkg::VALUE_W-1:0]    value_reg, value_next;
    logic signed [clce_pkg::VALUE_W-1:0]    new_value_reg, new_value_next;
    clce_pkg::slot_t                        head_reg, head_next;
    clce_pkg::slot_t                        cursor_reg, cursor_next;
    logic [clce_pkg::COUNT_W-1:0]           entry_count_reg, entry_count_next;
    clce_pkg::slot_t                        slot_reg, slot_next;
    clce_pkg::slot_t                        prev_reg, prev_next;
    clce_pkg::slot_t                        succ_reg, succ_next;
    clce_pkg::slot_t                        walk_slot_reg, walk_slot_next;
    logic [clce_pkg::COUNT_W-1:0]           walk_cnt_reg, walk_cnt_next;
    logic [clce_pkg::STATUS_W-1:0]          result_reg, result_next;
    logic                                   out_valid_reg, out_valid_next;
    logic [clce_pkg::STATUS_W-1:0]          status_reg, status_next;
    logic [clce_pkg::COUNT_OUT_W-1:0]       count_reg, count_next;

    clce_pkg::pool_cmd_t                    pool_cmd;
    clce_pkg::pool_resp_t                   pool_resp;

    logic                                   val_we;
    clce_pkg::slot_t                        val_waddr;
    logic [clce_pkg::VALUE_W-1:0]           val_wdata;
    logic [clce_pkg::VALUE_W-1:0]           val_rdata;
    logic                                   lnk_we;
    clce_pkg::slot_t                        lnk_waddr;
    clce_pkg::slot_t                        lnk_wdata;
    clce_pkg::slot_t                        lnk_rdata;
    clce_pkg::slot_t                        rd_addr;

    logic                                   accept;
    logic                                   hit;
    logic                                   walk_last;

    clce_ram #(
        .WIDTH (clce_pkg::VALUE_W),
        .DEPTH (clce_pkg::CAPACITY)
    ) u_values (
        .clk     (clk),
        .wr_en   (val_we),
        .wr_addr (val_waddr),
        .wr_data (val_wdata),
        .rd_addr (rd_addr),
        .rd_data (val_rdata)
    );

    clce_ram #(
        .WIDTH (clce_pkg::SLOT_W),
        .DEPTH (clce_pkg::CAPACITY)
    ) u_links (
        .clk     (clk),
        .wr_en   (lnk_we),
        .wr_addr (lnk_waddr),
        .wr_data (lnk_wdata),
        .rd_addr (rd_addr),
        .rd_data (lnk_rdata)
    );

    clce_slot_pool u_pool (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (pool_cmd),
        .resp  (pool_resp)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid & in_ready;
    assign hit       = ($signed(val_rdata) == value_reg);
    assign walk_last = (walk_cnt_reg == entry_count_reg - clce_pkg::COUNT_W'(1));
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign count     = count_reg;

    always_comb
    begin
        case (state_reg)
            S_WALK, S_TAIL: rd_addr = lnk_rdata;
            S_SCAN:         rd_addr = cursor_reg;
            default:        rd_addr = head_reg;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        value_next       = value_reg;
        new_value_next   = new_value_reg;
        head_next        = head_reg;
        cursor_next      = cursor_reg;
        entry_count_next = entry_count_reg;
        slot_next        = slot_reg;
        prev_next        = prev_reg;
        succ_next        = succ_reg;
        walk_slot_next   = walk_slot_reg;
        walk_cnt_next    = walk_cnt_reg;
        result_next      = result_reg;
        out_valid_next   = out_valid_reg & ~out_ready;
        status_next      = status_reg;
        count_next       = count_reg;
        pool_cmd         = '0;
        val_we           = 1'b0;
        val_waddr        = slot_reg;
        val_wdata        = value_reg;
        lnk_we           = 1'b0;
        lnk_waddr        = slot_reg;
        lnk_wdata        = slot_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next      = func;
                    value_next     = value;
                    new_value_next = new_value;
                    walk_slot_next = head_reg;
                    walk_cnt_next  = '0;
                    if (func == clce_pkg::FN_INSERT)
                    begin
                        if (entry_count_reg >= clce_pkg::COUNT_W'(clce_pkg::CAPACITY))
                        begin
                            result_next = clce_pkg::ST_FULL;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            pool_cmd.start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    else if (entry_count_reg == '0)
                    begin
                        result_next = clce_pkg::ST_NOT_FOUND;
                        cursor_next = head_reg;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end

            S_SCAN:
            begin
                if (pool_resp.done)
                begin
                    slot_next = pool_resp.slot;
                    val_we    = 1'b1;
                    val_waddr = pool_resp.slot;
                    if (entry_count_reg == '0)
                    begin
                        lnk_we           = 1'b1;
                        lnk_waddr        = pool_resp.slot;
                        lnk_wdata        = pool_resp.slot;
                        head_next        = pool_resp.slot;
                        cursor_next      = pool_resp.slot;
                        pool_cmd.take    = 1'b1;
                        pool_cmd.slot    = pool_resp.slot;
                        entry_count_next = entry_count_reg + clce_pkg::COUNT_W'(1);
                        result_next      = clce_pkg::ST_DONE;
                        state_next       = S_FIN;
                    end
                    else
                    begin
                        state_next = S_INS_LINK;
                    end
                end
            end

            S_INS_LINK:
            begin
                lnk_we     = 1'b1;
                lnk_waddr  = slot_reg;
                lnk_wdata  = lnk_rdata;
                state_next = S_INS_HOOK;
            end

            S_INS_HOOK:
            begin
                lnk_we           = 1'b1;
                lnk_waddr        = cursor_reg;
                lnk_wdata        = slot_reg;
                cursor_next      = slot_reg;
                pool_cmd.take    = 1'b1;
                pool_cmd.slot    = slot_reg;
                entry_count_next = entry_count_reg + clce_pkg::COUNT_W'(1);
                result_next      = clce_pkg::ST_DONE;
                state_next       = S_FIN;
            end

            S_WALK:
            begin
                if (hit)
                begin
                    slot_next   = walk_slot_reg;
                    succ_next   = lnk_rdata;
                    result_next = clce_pkg::ST_DONE;
                    case (func_reg)
                        clce_pkg::FN_REMOVE:
                        begin
                            if (entry_count_reg == clce_pkg::COUNT_W'(1))
                            begin
                                head_next        = '0;
                                cursor_next      = '0;
                                pool_cmd.give    = 1'b1;
                                pool_cmd.slot    = walk_slot_reg;
                                entry_count_next = entry_count_reg - clce_pkg::COUNT_W'(1);
                                state_next       = S_FIN;
                            end
                            else if (walk_cnt_reg == '0)
                            begin
                                walk_slot_next = lnk_rdata;
                                state_next     = S_TAIL;
                            end
                            else
                            begin
                                state_next = S_REM_WR;
                            end
                        end
                        clce_pkg::FN_UPDATE:
                        begin
                            val_we      = 1'b1;
                            val_waddr   = walk_slot_reg;
                            val_wdata   = new_value_reg;
                            cursor_next = walk_slot_reg;
                            state_next  = S_FIN;
                        end
                        default:
                        begin
                            cursor_next = walk_slot_reg;
                            state_next  = S_FIN;
                        end
                    endcase
                end
                else if (walk_last)
                begin
                    result_next = clce_pkg::ST_NOT_FOUND;
                    cursor_next = head_reg;
                    state_next  = S_FIN;
                end
                else
                begin
                    prev_next      = walk_slot_reg;
                    walk_slot_next = lnk_rdata;
                    walk_cnt_next  = walk_cnt_reg + clce_pkg::COUNT_W'(1);
                end
            end

            S_TAIL:
            begin
                if (lnk_rdata == slot_reg)
                begin
                    prev_next  = walk_slot_reg;
                    state_next = S_REM_WR;
                end
                else
                begin
                    walk_slot_next = lnk_rdata;
                end
            end

            S_REM_WR:
            begin
                lnk_we    = 1'b1;
                lnk_waddr = prev_reg;
                lnk_wdata = succ_reg;
                if (slot_reg == head_reg)
                begin
                    head_next = succ_reg;
                end
                cursor_next      = succ_reg;
                pool_cmd.give    = 1'b1;
                pool_cmd.slot    = slot_reg;
                entry_count_next = entry_count_reg - clce_pkg::COUNT_W'(1);
                state_next       = S_FIN;
            end

            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = result_reg;
                    count_next     = clce_pkg::COUNT_OUT_W'(entry_count_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            cursor_reg      <= '0;
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            cursor_reg      <= cursor_next;
            entry_count_reg <= entry_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        value_reg     <= value_next;
        new_value_reg <= new_value_next;
        slot_reg      <= slot_next;
        prev_reg      <= prev_next;
        succ_reg      <= succ_next;
        walk_slot_reg <= walk_slot_next;
        walk_cnt_reg  <= walk_cnt_next;
        result_reg    <= result_next;
        status_reg    <= status_next;
        count_reg     <= count_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= clce_pkg::COUNT_W'(clce_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pool_resp.done |-> (state_reg == S_SCAN))
        else $error("slot scan finished outside insert");

    a_count_change_src: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_count_reg != $past(entry_count_reg)) |->
            ($past(state_reg) == S_SCAN || $past(state_reg) == S_INS_HOOK ||
             $past(state_reg) == S_WALK || $past(state_reg) == S_REM_WR))
        else $error("entry count changed outside an insert or remove step");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result raised outside the finish step");

endmodule
